FILE: design/vel_pkg.sv
// ----------------------------------------------------------------------------
// vel_pkg
// Shared types, constants and character helpers for the visual escape
// line folder: item classes, the request descriptor and the escape tables.
// ----------------------------------------------------------------------------
package vel_pkg;

    localparam int COLUMN_BITS_DEF = 11;
    localparam int FOLD_W          = 10;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [FOLD_W-1:0] FOLD_RESET = 10'd72;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    typedef enum logic [2:0] {
        KIND_PLAIN  = 3'd0,
        KIND_LETTER = 3'd1,
        KIND_OCTAL  = 3'd2,
        KIND_BSL    = 3'd3,
        KIND_EOL    = 3'd4
    } kind_t;

    // one request as handed from front to back
    typedef struct packed {
        logic       fold;
        kind_t      kind;
        logic [7:0] ch;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // letter of a control escape, zero when the byte has none
    function automatic logic [7:0] escape_letter(input logic [7:0] c);
        logic [7:0] l;
        l = 8'h00;
        case (c)
            8'h08:   l = 8'h62;
            8'h09:   l = 8'h74;
            8'h0A:   l = 8'h6E;
            8'h0B:   l = 8'h76;
            8'h0C:   l = 8'h66;
            8'h0D:   l = 8'h72;
            default: l = 8'h00;
        endcase
        return l;
    endfunction

    function automatic kind_t classify(input logic [7:0] c);
        kind_t k;
        if (escape_letter(c) != 8'h00)
            k = KIND_LETTER;
        else if (c < PRINT_LO || c > PRINT_HI)
            k = KIND_OCTAL;
        else if (c == CH_BSL)
            k = KIND_BSL;
        else
            k = KIND_PLAIN;
        return k;
    endfunction

    // characters of the escaped body, also its column width
    function automatic logic [2:0] body_len(input kind_t k);
        logic [2:0] n;
        case (k)
            KIND_PLAIN:  n = 3'd1;
            KIND_LETTER: n = 3'd2;
            KIND_OCTAL:  n = 3'd4;
            KIND_BSL:    n = 3'd2;
            KIND_EOL:    n = 3'd1;
            default:     n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

FILE: design/visual_escape_line_folder.sv
// ----------------------------------------------------------------------------
// visual_escape_line_folder
// Rewrites text bytes in visible escaped form and folds long output lines.
//
//   channel  direction  signals                          carries
//   in       input      in_valid in_ready cmd ch         text byte / end of line
//   out      output     out_valid out_ready out_char last one output character
//   cfg      input      cfg_valid cfg_ready cfg_data     fold width write
//
// one output character per cycle while the output is not stalled;
// an item gives 1 to 5 characters
// the front takes an item each cycle while the 4-entry request queue has room
// reset sets fold width to 72, column to 1 and empties the queue
// an output stall holds the character and fills the queue, then in_ready drops
// ----------------------------------------------------------------------------
module visual_escape_line_folder #(
    parameter int COLUMN_BITS = vel_pkg::COLUMN_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [7:0]                 ch,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_char,
    output logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [vel_pkg::FOLD_W-1:0] cfg_data
);

    vel_pkg::q_status_t q_status;
    vel_pkg::desc_t     q_wdata;
    vel_pkg::desc_t     q_rdata;
    logic               q_push;
    logic               q_pop;

    vel_front #(
        .COLUMN_BITS(COLUMN_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .ch        (ch),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    vel_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    vel_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last)
    );

endmodule

FILE: design/vel_front.sv
// ----------------------------------------------------------------------------
// vel_front
// Accepts items, classifies each byte, keeps the running column and the
// fold width register, and decides where the output line is broken.
// ----------------------------------------------------------------------------
module vel_front #(
    parameter int COLUMN_BITS = vel_pkg::COLUMN_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      cmd,
    input  logic [7:0]                ch,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [vel_pkg::FOLD_W-1:0] cfg_data,
    input  vel_pkg::q_status_t        q_status,
    output logic                      q_push,
    output vel_pkg::desc_t            q_wdata
);

    localparam int CMP_W = (COLUMN_BITS > vel_pkg::FOLD_W) ? COLUMN_BITS : vel_pkg::FOLD_W;
    localparam logic [COLUMN_BITS-1:0] COL_ONE = {{(COLUMN_BITS-1){1'b0}}, 1'b1};

    logic [vel_pkg::FOLD_W-1:0] fold_width_reg;
    logic [COLUMN_BITS-1:0]     column_reg;
    logic [COLUMN_BITS-1:0]     column_next;
    logic [COLUMN_BITS-1:0]     base;
    logic [COLUMN_BITS:0]       sum;
    logic                       fold_hit;
    vel_pkg::kind_t             kind;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_status.full;
    assign q_push    = in_valid && in_ready;

    always_comb
    begin
        fold_hit = CMP_W'(column_reg) > CMP_W'(fold_width_reg);
        base     = fold_hit ? '0 : column_reg;
        if (cmd == vel_pkg::CMD_EOL)
            kind = vel_pkg::KIND_EOL;
        else
            kind = vel_pkg::classify(ch);
        sum = {1'b0, base} + (COLUMN_BITS+1)'(vel_pkg::body_len(kind));
        // saturate rather than wrap
        if (cmd == vel_pkg::CMD_EOL)
            column_next = COL_ONE;
        else if (sum[COLUMN_BITS])
            column_next = '1;
        else
            column_next = sum[COLUMN_BITS-1:0];
        q_wdata.fold = (cmd == vel_pkg::CMD_BYTE) && fold_hit;
        q_wdata.kind = kind;
        q_wdata.ch   = ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_width_reg <= vel_pkg::FOLD_RESET;
            column_reg     <= COL_ONE;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                fold_width_reg <= cfg_data;
            if (q_push)
                column_reg <= column_next;
        end
    end

endmodule

FILE: design/vel_queue.sv
// ----------------------------------------------------------------------------
// vel_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module vel_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vel_pkg::desc_t     wdata,
    input  logic               pop,
    output vel_pkg::desc_t     rdata,
    output vel_pkg::q_status_t status
);

    localparam int AW = $clog2(vel_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(vel_pkg::QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(vel_pkg::QUEUE_DEPTH);

    vel_pkg::desc_t  slot_reg [vel_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign status.full  = (count_reg == DEPTH_C);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= AW'(({1'b0, wr_ptr_reg} + (AW+1)'(1)) % vel_pkg::QUEUE_DEPTH);
            if (do_pop)
                rd_ptr_reg <= AW'(({1'b0, rd_ptr_reg} + (AW+1)'(1)) % vel_pkg::QUEUE_DEPTH);
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/vel_back.sv
// ----------------------------------------------------------------------------
// vel_back
// Expands the request at the head of the queue into output characters,
// one per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module vel_back (
    input  logic               clk,
    input  logic               rst_n,
    input  vel_pkg::q_status_t q_status,
    input  vel_pkg::desc_t     q_rdata,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_char,
    output logic               last
);

    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       last_reg;
    logic       load;
    logic       last_step;
    logic [2:0] total;
    logic [2:0] k;
    logic [7:0] body_char;
    logic [7:0] next_char;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    always_comb
    begin
        total     = vel_pkg::body_len(q_rdata.kind) + {2'b00, q_rdata.fold};
        last_step = (step_reg == total - 3'd1);
        load      = !q_status.empty && (!out_valid_reg || out_ready);
        q_pop     = load && last_step;
        k         = step_reg - {2'b00, q_rdata.fold};

        case (q_rdata.kind)
            vel_pkg::KIND_PLAIN:  body_char = q_rdata.ch;
            vel_pkg::KIND_EOL:    body_char = vel_pkg::CH_NL;
            vel_pkg::KIND_BSL:    body_char = vel_pkg::CH_BSL;
            vel_pkg::KIND_LETTER:
                body_char = (k == 3'd0) ? vel_pkg::CH_BSL : vel_pkg::escape_letter(q_rdata.ch);
            vel_pkg::KIND_OCTAL:
            begin
                case (k)
                    3'd0:    body_char = vel_pkg::CH_BSL;
                    3'd1:    body_char = vel_pkg::CH_ZERO + {6'd0, q_rdata.ch[7:6]};
                    3'd2:    body_char = vel_pkg::CH_ZERO + {5'd0, q_rdata.ch[5:3]};
                    default: body_char = vel_pkg::CH_ZERO + {5'd0, q_rdata.ch[2:0]};
                endcase
            end
            default:              body_char = q_rdata.ch;
        endcase

        // fold newline goes ahead of the body
        next_char = (q_rdata.fold && step_reg == 3'd0) ? vel_pkg::CH_NL : body_char;

        step_next = step_reg;
        if (load)
            step_next = last_step ? 3'd0 : step_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= next_char;
            last_reg     <= last_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

FILE: design/vel_checker.sv
// ----------------------------------------------------------------------------
// vel_checker
// Port-level checks on the output stream of the visual escape line folder.
// ----------------------------------------------------------------------------
module vel_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       last
);

    // a stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
        else $error("output changed while stalled");

    // every character shown is visible or a newline
    a_visible: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_char == 8'h0A || (out_char >= 8'd32 && out_char <= 8'd126))
        else $error("invisible character on output");

    // only a fold newline, a backslash or an octal digit can precede more of a request
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> out_char == 8'h0A || out_char == 8'h5C
                               || (out_char >= 8'h30 && out_char <= 8'h37))
        else $error("unexpected character inside a request");

    // the rest of a request follows without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside a request");

endmodule

bind visual_escape_line_folder vel_checker u_vel_checker (.*);
